### rtl/oomq_pkg.sv
// shared types and constants for the oldest-or-max queue
`timescale 1ns / 1ps

package oomq_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int VALUE_W          = 32;
    localparam int ID_W             = 32;
    localparam int FUNC_W           = 2;
    localparam int STATUS_W         = 2;

    localparam logic [FUNC_W-1:0] FN_INSERT  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_OLDEST  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_LARGEST = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_UNUSED = 2'd3;

    typedef struct packed {
        logic                      valid;
        logic [ID_W-1:0]           id;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic                      has;
        logic [ID_W-1:0]           id;
        logic signed [VALUE_W-1:0] value;
    } cand_t;

    typedef struct packed {
        logic ins;
        logic shift;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DONE
    } state_t;

endpackage

### rtl/oomq_cell.sv
// one storage cell of the queue chain with its stage of the max sweep
`timescale 1ns / 1ps

module oomq_cell
    import oomq_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter int INDEX = 0
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cell_ctl_t                 ctl,
    input  logic [IDX_W-1:0]          shift_idx,
    input  logic [ID_W-1:0]           ins_id,
    input  logic signed [VALUE_W-1:0] ins_value,
    input  logic                      prev_valid,
    input  entry_t                    next_entry,
    output entry_t                    entry,
    input  logic                      tok_in,
    input  cand_t                     cand_in,
    input  logic [IDX_W-1:0]          cand_idx_in,
    output logic                      tok_out,
    output cand_t                     cand_out,
    output logic [IDX_W-1:0]          cand_idx_out
);

    logic                      valid_reg, valid_next;
    logic [ID_W-1:0]           id_reg, id_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic                      tok_reg;
    cand_t                     cand_reg, cand_next;
    logic [IDX_W-1:0]          cidx_reg, cidx_next;
    logic                      ins_here;
    logic                      shift_here;
    logic                      take;

    assign ins_here   = ctl.ins && !valid_reg && prev_valid;
    assign shift_here = ctl.shift && (IDX_W'(INDEX) >= shift_idx);

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        value_next = value_reg;
        if (ins_here)
        begin
            valid_next = 1'b1;
            id_next    = ins_id;
            value_next = ins_value;
        end
        else if (shift_here)
        begin
            valid_next = next_entry.valid;
            id_next    = next_entry.id;
            value_next = next_entry.value;
        end
    end

    // strictly greater keeps the older entry on a tie
    assign take = tok_in && valid_reg && (!cand_in.has || (value_reg > cand_in.value));

    always_comb
    begin
        cand_next = cand_in;
        cidx_next = cand_idx_in;
        if (take)
        begin
            cand_next = '{has: 1'b1, id: id_reg, value: value_reg};
            cidx_next = IDX_W'(INDEX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        value_reg <= value_next;
        cand_reg  <= cand_next;
        cidx_reg  <= cidx_next;
    end

    assign entry        = '{valid: valid_reg, id: id_reg, value: value_reg};
    assign tok_out      = tok_reg;
    assign cand_out     = cand_reg;
    assign cand_idx_out = cidx_reg;

endmodule

### rtl/oldest_or_max_queue.sv
// top level: bounded pool with take-oldest and take-largest over a cell chain
// results: insert, take-oldest and any empty or full case register the result on
// acceptance; take-largest registers it after the sweep through the cell chain and S_DONE
// throughput: one item per cycle for insert and take-oldest while the output is not
// stalled; take-largest holds off new requests until its sweep is done and its result loaded
// reset: rst_n clears the cell valid bits, the id counter and the output valid at once
`timescale 1ns / 1ps

module oldest_or_max_queue
    import oomq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // item_value[31:0]
    input  logic [1:0]  s_axis_tuser,  // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // entry_id[31:0], entry_value[63:32]
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    localparam int IDX_W = $clog2(CAPACITY);

    state_t state_reg, state_next;

    entry_t                ent      [CAPACITY];
    logic                  tok      [CAPACITY];
    cand_t                 cand     [CAPACITY];
    logic [IDX_W-1:0]      cidx     [CAPACITY];

    cell_ctl_t             ctl;
    logic [IDX_W-1:0]      shift_idx;
    logic                  tok0;

    logic [ID_W-1:0]       next_id_reg, next_id_next;
    logic [ID_W-1:0]       ins_id;

    logic [ID_W-1:0]       win_id_reg;
    logic signed [VALUE_W-1:0] win_value_reg;
    logic [IDX_W-1:0]      win_idx_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [ID_W-1:0]       out_id_reg, out_id_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic                  load_out;

    logic                  out_free;
    logic                  acc;
    logic                  full;
    logic                  empty;
    logic                  is_ins;
    logic                  is_old;
    logic                  is_max;
    logic signed [VALUE_W-1:0] item_value;

    assign item_value = s_axis_tdata;
    assign full       = ent[CAPACITY-1].valid;
    assign empty      = !ent[0].valid;
    assign is_ins     = (s_axis_tuser == FN_INSERT);
    assign is_old     = (s_axis_tuser == FN_OLDEST);
    assign is_max     = !is_ins && !is_old;
    assign ins_id     = next_id_reg + ID_W'(1);

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign acc           = s_axis_tvalid && s_axis_tready;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            entry_t           nxt;
            logic             pv;
            logic             tin;
            cand_t            cin;
            logic [IDX_W-1:0] iin;

            if (gi == CAPACITY - 1)
            begin : g_top
                assign nxt = '0;
            end
            else
            begin : g_mid
                assign nxt = ent[gi+1];
            end

            if (gi == 0)
            begin : g_first
                assign pv  = 1'b1;
                assign tin = tok0;
                assign cin = '0;
                assign iin = '0;
            end
            else
            begin : g_rest
                assign pv  = ent[gi-1].valid;
                assign tin = tok[gi-1];
                assign cin = cand[gi-1];
                assign iin = cidx[gi-1];
            end

            oomq_cell #(
                .IDX_W (IDX_W),
                .INDEX (gi)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctl          (ctl),
                .shift_idx    (shift_idx),
                .ins_id       (ins_id),
                .ins_value    (item_value),
                .prev_valid   (pv),
                .next_entry   (nxt),
                .entry        (ent[gi]),
                .tok_in       (tin),
                .cand_in      (cin),
                .cand_idx_in  (iin),
                .tok_out      (tok[gi]),
                .cand_out     (cand[gi]),
                .cand_idx_out (cidx[gi])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc && is_max && !empty)
                    state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                if (tok[CAPACITY-1])
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        ctl.ins         = 1'b0;
        ctl.shift       = 1'b0;
        shift_idx       = '0;
        tok0            = 1'b0;
        load_out        = 1'b0;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_value_next  = out_value_reg;
        next_id_next    = next_id_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (is_ins)
                    begin
                        load_out = 1'b1;
                        if (full)
                        begin
                            out_status_next = STAT_FULL;
                            out_id_next     = '0;
                            out_value_next  = '0;
                        end
                        else
                        begin
                            ctl.ins         = 1'b1;
                            next_id_next    = ins_id;
                            out_status_next = STAT_OK;
                            out_id_next     = ins_id;
                            out_value_next  = item_value;
                        end
                    end
                    else if (empty)
                    begin
                        load_out        = 1'b1;
                        out_status_next = STAT_EMPTY;
                        out_id_next     = '0;
                        out_value_next  = '0;
                    end
                    else if (is_old)
                    begin
                        load_out        = 1'b1;
                        ctl.shift       = 1'b1;
                        out_status_next = STAT_OK;
                        out_id_next     = ent[0].id;
                        out_value_next  = ent[0].value;
                    end
                    else
                    begin
                        tok0 = 1'b1;
                    end
                end
            end
            S_SWEEP:
            begin
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    load_out        = 1'b1;
                    ctl.shift       = 1'b1;
                    shift_idx       = win_idx_reg;
                    out_status_next = STAT_OK;
                    out_id_next     = win_id_reg;
                    out_value_next  = win_value_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            next_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_value_reg  <= out_value_next;
        if ((state_reg == S_SWEEP) && tok[CAPACITY-1])
        begin
            win_id_reg    <= cand[CAPACITY-1].id;
            win_value_reg <= cand[CAPACITY-1].value;
            win_idx_reg   <= cidx[CAPACITY-1];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_value_reg, out_id_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

### rtl/oomq_checker.sv
// port-level checks for the oldest-or-max queue and their binding
`timescale 1ns / 1ps

module oomq_checker
    import oomq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

    // an accepted insert transaction answers in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == FN_INSERT) |=> m_axis_tvalid)
    else $error("insert result late");

    // empty and full results carry no entry
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tuser == STAT_EMPTY) || (m_axis_tuser == STAT_FULL))
        |-> (m_axis_tdata == 64'd0))
    else $error("rejected transaction carries data");

    // no unused status code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser != STAT_UNUSED))
    else $error("bad status code");

endmodule

bind oldest_or_max_queue oomq_checker u_oomq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
